[sv/arena_array_store_assert.svh]
// assertion macros shared by the arena array store rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ARENA_ARRAY_STORE_ASSERT_SVH
`define ARENA_ARRAY_STORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AAS_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("arena array store check failed");

// next-cycle implication, disabled during reset
`define AAS_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("arena array store check failed");

`endif

[sv/aas_pkg.sv]
// types, constants and codes for the arena array store
// no dependencies
package aas_pkg;

    localparam int PAGE_W     = 10;
    localparam int PAGE_IDX_W = 2;
    localparam int MEM_ADDR_W = PAGE_W + PAGE_IDX_W;
    localparam int MEM_WORDS  = 1 << MEM_ADDR_W;
    localparam int PAGE_COUNT = 1 << PAGE_IDX_W;
    localparam int MAX_DIMS   = 4;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic CFG_PAGE_SLOTS = 1'b0;
    localparam logic CFG_PAGE_LIMIT = 1'b1;

    localparam logic [63:0] ERR_NULL_INT = 64'h0000_0000_FFFF_FFFE;
    localparam logic [63:0] ERR_NULL_DBL = 64'hC000_0000_0000_0000;
    localparam logic [63:0] ERR_OOB_INT  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] ERR_OOB_DBL  = 64'hBFF0_0000_0000_0000;

    localparam logic [32:0] SIZE_CAP = 33'h1_0000_0000;

    typedef struct packed {
        logic [1:0]         op;
        logic               elem_is_double;
        logic [2:0]         n_dims;
        logic signed [31:0] index_0;
        logic signed [31:0] index_1;
        logic signed [31:0] index_2;
        logic signed [31:0] index_3;
        logic [11:0]        handle;
        logic [63:0]        value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] data;
        logic        ok;
        logic [11:0] handle_out;
    } out_item_t;

endpackage

[sv/aas_ram.sv]
// generic single-port ram with registered read
// no dependencies
module aas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read before write, read data registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[sv/arena_array_store.sv]
// arena array store: one item at a time; a clear, an access or an allocation ends before the next is taken,
// and an allocation that opens a page first zeroes every slot of that page.
// the slot ram port is the shared resource; one slot read or write per cycle,
// one size multiply per dimension through a single multiplier.
// aresetn synchronous active low: no page, page_slots 1023, page_limit 4;
// slot memory is not cleared, a page is zeroed only when it is opened.
module arena_array_store
    import aas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_wdata
);

`include "arena_array_store_assert.svh"

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_FILL = 4'd3;
    localparam logic [3:0] S_HRD  = 4'd4;
    localparam logic [3:0] S_HWR  = 4'd5;
    localparam logic [3:0] S_ARD  = 4'd6;
    localparam logic [3:0] S_ACHK = 4'd7;
    localparam logic [3:0] S_ERD  = 4'd8;
    localparam logic [3:0] S_EFIN = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]            state_reg, state_next;
    in_item_t              in_reg, in_next;
    out_item_t             out_reg, out_next;
    logic [PAGE_W-1:0]     page_slots_reg, page_slots_next;
    logic [2:0]            page_limit_reg, page_limit_next;
    logic [PAGE_IDX_W-1:0] cur_page_reg, cur_page_next;
    logic [PAGE_IDX_W-1:0] fill_page_reg, fill_page_next;
    logic [PAGE_W:0]       next_slot_reg, next_slot_next;
    logic [PAGE_W:0]       free_reg, free_next;
    logic [2:0]            opened_reg, opened_next;
    logic [1:0]            dim_reg, dim_next;
    logic [32:0]           total_reg, total_next;
    logic [PAGE_W:0]       need_reg, need_next;
    logic [12:0]           pos_reg, pos_next;
    logic [PAGE_W-1:0]     fill_reg, fill_next;

    logic                  ram_we;
    logic [MEM_ADDR_W-1:0] ram_addr;
    logic [63:0]           ram_wdata, ram_rdata;

    logic signed [31:0]    idx_sel;
    logic                  last_dim;
    logic [63:0]           prod;
    logic [33:0]           words;
    logic [34:0]           need_full;
    logic [2:0]            lim;
    logic [MEM_ADDR_W-1:0] alloc_base, elem_addr;
    logic signed [31:0]    dim_val;
    logic [63:0]           oob_data, null_data;

    aas_ram #(
        .WIDTH (64),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // shared datapath terms
    always_comb begin
        case (dim_reg)
            2'd0:    idx_sel = in_reg.index_0;
            2'd1:    idx_sel = in_reg.index_1;
            2'd2:    idx_sel = in_reg.index_2;
            default: idx_sel = in_reg.index_3;
        endcase
        last_dim   = (({1'b0, dim_reg} + 3'd1) == in_reg.n_dims);
        prod       = total_reg * {2'b00, idx_sel[30:0]};
        words      = in_reg.elem_is_double ? {1'b0, total_reg}
                                           : 34'(({1'b0, total_reg} + 34'd1) >> 1);
        if (words == 34'd0) begin
            words = 34'd1;
        end
        need_full  = {1'b0, words} + 35'(in_reg.n_dims);
        lim        = (page_limit_reg > 3'(PAGE_COUNT)) ? 3'(PAGE_COUNT) : page_limit_reg;
        alloc_base = {cur_page_reg, PAGE_W'(0)} + MEM_ADDR_W'(next_slot_reg);
        elem_addr  = in_reg.handle + MEM_ADDR_W'(in_reg.n_dims)
                   + (in_reg.elem_is_double ? MEM_ADDR_W'(pos_reg)
                                            : MEM_ADDR_W'(pos_reg >> 1));
        dim_val    = ram_rdata[31:0];
        oob_data   = in_reg.elem_is_double ? ERR_OOB_DBL : ERR_OOB_INT;
        null_data  = in_reg.elem_is_double ? ERR_NULL_DBL : ERR_NULL_INT;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        in_next         = in_reg;
        out_next        = out_reg;
        page_slots_next = page_slots_reg;
        page_limit_next = page_limit_reg;
        cur_page_next   = cur_page_reg;
        fill_page_next  = fill_page_reg;
        next_slot_next  = next_slot_reg;
        free_next       = free_reg;
        opened_next     = opened_reg;
        dim_next        = dim_reg;
        total_next      = total_reg;
        need_next       = need_reg;
        pos_next        = pos_reg;
        fill_next       = fill_reg;
        ram_we          = 1'b0;
        ram_addr        = alloc_base + MEM_ADDR_W'(dim_reg);
        ram_wdata       = {ram_rdata[63:32], idx_sel};

        // configuration writes
        if (cfg_we) begin
            case (cfg_index)
                CFG_PAGE_SLOTS: page_slots_next = cfg_wdata;
                CFG_PAGE_LIMIT: page_limit_next = cfg_wdata[2:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    out_next   = '0;
                    dim_next   = '0;
                    pos_next   = '0;
                    total_next = 33'd1;
                    case (s_data.op)
                        OP_ALLOC: begin
                            if (s_data.n_dims == 3'd0 || s_data.n_dims > 3'(MAX_DIMS)) begin
                                state_next = S_OUT;
                            end else begin
                                state_next = S_MUL;
                            end
                        end
                        OP_READ, OP_WRITE: begin
                            if (s_data.handle == '0) begin
                                if (s_data.op == OP_READ) begin
                                    out_next.data = s_data.elem_is_double ? ERR_NULL_DBL
                                                                          : ERR_NULL_INT;
                                end
                                state_next = S_OUT;
                            end else if (s_data.n_dims == 3'd0
                                         || s_data.n_dims > 3'(MAX_DIMS)) begin
                                if (s_data.op == OP_READ) begin
                                    out_next.data = s_data.elem_is_double ? ERR_OOB_DBL
                                                                          : ERR_OOB_INT;
                                end
                                state_next = S_OUT;
                            end else begin
                                state_next = S_ARD;
                            end
                        end
                        default: begin
                            if (opened_reg != 3'd0) begin
                                opened_next    = 3'd1;
                                free_next      = {1'b0, page_slots_reg};
                                next_slot_next = (PAGE_W+1)'(1);
                            end
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            // one saturating size multiply per cycle
            S_MUL: begin
                if (idx_sel[31]) begin
                    state_next = S_OUT;
                end else begin
                    total_next = (prod > 64'(SIZE_CAP)) ? SIZE_CAP : prod[32:0];
                    dim_next   = dim_reg + 2'd1;
                    if (last_dim) begin
                        dim_next   = '0;
                        state_next = S_CHK;
                    end
                end
            end
            // room check, page open
            S_CHK: begin
                need_next = need_full[PAGE_W:0];
                if (need_full > 35'(page_slots_reg)) begin
                    state_next = S_OUT;
                end else if (35'(free_reg) >= need_full) begin
                    state_next = S_HRD;
                end else if (opened_reg >= lim) begin
                    state_next = S_OUT;
                end else begin
                    fill_page_next = (opened_reg != 3'd0) ? cur_page_reg + 1'b1 : '0;
                    fill_next      = '0;
                    state_next     = S_FILL;
                end
            end
            // zero the new page, one slot a cycle
            S_FILL: begin
                ram_we    = 1'b1;
                ram_addr  = {fill_page_reg, fill_reg};
                ram_wdata = '0;
                fill_next = fill_reg + 1'b1;
                if (&fill_reg) begin
                    cur_page_next  = fill_page_reg;
                    opened_next    = opened_reg + 3'd1;
                    free_next      = {1'b0, page_slots_reg};
                    next_slot_next = (PAGE_W+1)'(1);
                    state_next     = S_HRD;
                end
            end
            S_HRD: begin
                state_next = S_HWR;
            end
            // header slot keeps its upper half
            S_HWR: begin
                ram_we   = 1'b1;
                dim_next = dim_reg + 2'd1;
                if (last_dim) begin
                    next_slot_next      = next_slot_reg + need_reg;
                    free_next           = free_reg - need_reg;
                    out_next.ok         = 1'b1;
                    out_next.handle_out = alloc_base;
                    state_next          = S_OUT;
                end else begin
                    state_next = S_HRD;
                end
            end
            S_ARD: begin
                ram_addr   = in_reg.handle + MEM_ADDR_W'(dim_reg);
                state_next = S_ACHK;
            end
            // bounds check and row-major step, low bits only
            S_ACHK: begin
                if (idx_sel < 0 || idx_sel >= dim_val) begin
                    if (in_reg.op == OP_READ) begin
                        out_next.data = oob_data;
                    end
                    state_next = S_OUT;
                end else begin
                    pos_next = 13'(pos_reg * dim_val[12:0]) + idx_sel[12:0];
                    dim_next = dim_reg + 2'd1;
                    state_next = last_dim ? S_ERD : S_ARD;
                end
            end
            S_ERD: begin
                ram_addr   = elem_addr;
                state_next = S_EFIN;
            end
            // element transfer
            S_EFIN: begin
                ram_addr    = elem_addr;
                out_next.ok = 1'b1;
                if (in_reg.op == OP_WRITE) begin
                    ram_we = 1'b1;
                    if (in_reg.elem_is_double) begin
                        ram_wdata = in_reg.value;
                    end else if (pos_reg[0]) begin
                        ram_wdata = {in_reg.value[31:0], ram_rdata[31:0]};
                    end else begin
                        ram_wdata = {ram_rdata[63:32], in_reg.value[31:0]};
                    end
                end else if (in_reg.elem_is_double) begin
                    out_next.data = ram_rdata;
                end else begin
                    out_next.data = {32'd0, pos_reg[0] ? ram_rdata[63:32] : ram_rdata[31:0]};
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            page_slots_reg <= PAGE_W'(1023);
            page_limit_reg <= 3'd4;
            cur_page_reg   <= '0;
            next_slot_reg  <= (PAGE_W+1)'(1);
            free_reg       <= '0;
            opened_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            page_slots_reg <= page_slots_next;
            page_limit_reg <= page_limit_next;
            cur_page_reg   <= cur_page_next;
            next_slot_reg  <= next_slot_next;
            free_reg       <= free_next;
            opened_reg     <= opened_next;
        end
        in_reg        <= in_next;
        out_reg       <= out_next;
        fill_page_reg <= fill_page_next;
        dim_reg       <= dim_next;
        total_reg     <= total_next;
        need_reg      <= need_next;
        pos_reg       <= pos_next;
        fill_reg      <= fill_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = out_reg;

    `AAS_ASSERT_IMP(a_room, aclk, aresetn, opened_reg != 3'd0, (12'(free_reg) + 12'(next_slot_reg)) <= 12'd1024)
    `AAS_ASSERT_IMP(a_pages, aclk, aresetn, 1'b1, opened_reg <= 3'(PAGE_COUNT))
    `AAS_ASSERT_NXT(a_ret, aclk, aresetn, m_valid && m_ready, s_ready && !m_valid)
    `AAS_ASSERT_IMP(a_handle, aclk, aresetn, m_valid && m_data.ok && in_reg.op == OP_ALLOC, m_data.handle_out != 12'd0)

endmodule

[bench/arena_array_store_tb.sv]
// self-checking testbench for the arena array store: directed table, then random traffic
// depends on aas_pkg and arena_array_store; predicts results in its own arena model, directed rows may give their own
`timescale 1ns / 100ps

module arena_array_store_tb;
    import aas_pkg::*;

    localparam int IDLE_LIMIT = 8000;
    localparam int N_RANDOM   = 750;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [9:0]  cfg_wdata = '0;

    arena_array_store DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // arena model state
    logic [63:0] slots [MEM_WORDS];
    bit          page_seen [PAGE_COUNT];
    int unsigned cur_pg, nxt_slot, room_left, n_pages;
    int unsigned pg_slots_reg, pg_limit_reg;

    out_item_t   pending_results [$];
    logic [11:0] live_handles [$];
    int          n_errors = 0;
    bit          stim_done = 1'b0;

    function automatic int unsigned usable_slots();
        return pg_slots_reg > 1023 ? 1023 : pg_slots_reg;
    endfunction

    function automatic bit open_next_page();
        int unsigned lim, p;
        lim = pg_limit_reg > PAGE_COUNT ? PAGE_COUNT : pg_limit_reg;
        if (n_pages >= lim) return 1'b0;
        p = (n_pages != 0) ? (cur_pg + 1) % PAGE_COUNT : 0;
        for (int k = 0; k < 1024; k++) slots[p * 1024 + k] = '0;
        page_seen[p] = 1'b1;
        cur_pg = p;
        n_pages++;
        room_left = usable_slots();
        nxt_slot = 1;
        return 1'b1;
    endfunction

    function automatic longint field_idx(in_item_t it, int k);
        case (k)
            0: return longint'(it.index_0);
            1: return longint'(it.index_1);
            2: return longint'(it.index_2);
            default: return longint'(it.index_3);
        endcase
    endfunction

    // row-major position of an access; in_bounds low when any index fails
    function automatic void locate(in_item_t it, output logic [63:0] pos, output bit in_bounds);
        longint ix, dim;
        pos = '0;
        in_bounds = 1'b0;
        if (it.n_dims < 1 || it.n_dims > MAX_DIMS) return;
        for (int k = 0; k < it.n_dims; k++) begin
            ix  = field_idx(it, k);
            dim = longint'($signed(slots[(it.handle + k) % MEM_WORDS][31:0]));
            if (ix < 0 || ix >= dim) return;
            pos = pos * dim + ix;
        end
        in_bounds = 1'b1;
    endfunction

    function automatic logic [11:0] elem_addr(in_item_t it, logic [63:0] pos);
        return 12'(it.handle + it.n_dims + (it.elem_is_double ? pos : pos >> 1));
    endfunction

    // an access may only touch pages that have been opened at some point
    function automatic bit touches_opened(in_item_t it);
        logic [63:0] pos;
        bit          inb;
        if (!(it.op inside {OP_READ, OP_WRITE}) || it.handle == 0) return 1'b1;
        if (it.n_dims < 1 || it.n_dims > MAX_DIMS) return 1'b1;
        for (int k = 0; k < it.n_dims; k++)
            if (!page_seen[((it.handle + k) % MEM_WORDS) >> 10]) return 1'b0;
        locate(it, pos, inb);
        return !inb || page_seen[elem_addr(it, pos) >> 10];
    endfunction

    function automatic out_item_t predict_arena(in_item_t it);
        out_item_t   r;
        logic [63:0] total, words, need, pos, w;
        logic [11:0] addr;
        bit          inb;
        longint      sz;
        r = '0;
        case (it.op)
            OP_ALLOC: begin
                if (it.n_dims < 1 || it.n_dims > MAX_DIMS) return r;
                total = 1;
                for (int k = 0; k < it.n_dims; k++) begin
                    sz = field_idx(it, k);
                    if (sz < 0) return r;
                    total = total * sz;
                    if (total > SIZE_CAP) total = SIZE_CAP;
                end
                words = it.elem_is_double ? total : (total + 1) / 2;
                if (words < 1) words = 1;
                need = words + it.n_dims;
                if (need > usable_slots()) return r;
                if (room_left < need && !open_next_page()) return r;
                addr = 12'(cur_pg * 1024 + nxt_slot);
                for (int k = 0; k < it.n_dims; k++)
                    slots[12'(addr + k)][31:0] = 32'(field_idx(it, k));
                nxt_slot += 32'(need);
                room_left -= 32'(need);
                r.ok = 1'b1;
                r.handle_out = addr;
            end
            OP_READ, OP_WRITE: begin
                if (it.handle == 0) begin
                    if (it.op == OP_READ) r.data = it.elem_is_double ? ERR_NULL_DBL : ERR_NULL_INT;
                    return r;
                end
                locate(it, pos, inb);
                if (!inb) begin
                    if (it.op == OP_READ) r.data = it.elem_is_double ? ERR_OOB_DBL : ERR_OOB_INT;
                    return r;
                end
                addr = elem_addr(it, pos);
                w = slots[addr];
                if (it.op == OP_WRITE) begin
                    if (it.elem_is_double) w = it.value;
                    else if (pos[0]) w[63:32] = it.value[31:0];
                    else w[31:0] = it.value[31:0];
                    slots[addr] = w;
                end else begin
                    r.data = it.elem_is_double ? w : (pos[0] ? {32'd0, w[63:32]} : {32'd0, w[31:0]});
                end
                r.ok = 1'b1;
            end
            default: begin
                if (n_pages > 0) begin
                    n_pages = 1;
                    room_left = usable_slots();
                    nxt_slot = 1;
                end
            end
        endcase
        return r;
    endfunction

    // offer one item and hold it until the transfer; the result goes on the pending list
    task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
        out_item_t r;
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        r = predict_arena(it);
        if (r.ok && it.op == OP_ALLOC) live_handles.push_back(r.handle_out);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic sender_gap(int n);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // register writes only once the block has gone quiet
    task automatic write_config(int unsigned slots_v, int unsigned limit_v);
        sender_gap(1);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        @(negedge aclk);
        cfg_we = 1'b1; cfg_index = CFG_PAGE_SLOTS; cfg_wdata = 10'(slots_v);
        @(negedge aclk);
        cfg_index = CFG_PAGE_LIMIT; cfg_wdata = 10'(limit_v);
        @(negedge aclk);
        cfg_we = 1'b0;
        pg_slots_reg = slots_v;
        pg_limit_reg = limit_v;
    endtask

    function automatic in_item_t mk(logic [1:0] op, bit dbl, int nd, int i0, int i1, int i2,
                                     int i3, int h, logic [63:0] v);
        in_item_t it;
        it.op = op; it.elem_is_double = dbl; it.n_dims = 3'(nd);
        it.index_0 = i0; it.index_1 = i1; it.index_2 = i2; it.index_3 = i3;
        it.handle = 12'(h); it.value = v;
        return it;
    endfunction

    function automatic out_item_t res(logic [63:0] d, bit ok, int h);
        out_item_t r;
        r.data = d; r.ok = ok; r.handle_out = 12'(h);
        return r;
    endfunction

    function automatic in_item_t random_item();
        in_item_t     it;
        int unsigned  pick, nd;
        longint       dim;
        logic [223:0] raw;
        it = '0;
        it.value = {$urandom, $urandom};
        it.elem_is_double = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            // allocation with mostly small sizes
            it.op = OP_ALLOC;
            nd = $urandom_range(1, 4);
            it.n_dims = 3'(nd);
            it.index_0 = $urandom_range(0, 6);
            it.index_1 = $urandom_range(0, 4);
            it.index_2 = $urandom_range(0, 3);
            it.index_3 = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0) it.index_1 = $urandom;
            if ($urandom_range(0, 14) == 0) it.index_0 = -$urandom_range(1, 5);
            if ($urandom_range(0, 14) == 0) it.index_0 = $urandom_range(100, 1100);
        end else if (pick < 85 && live_handles.size() != 0) begin
            // access through a known handle, mostly inside the bounds
            it.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
            it.handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
            nd = 0;
            while (nd < MAX_DIMS && slots[12'(it.handle + nd)][31:0] != 0 && nd < 4) nd++;
            if (nd == 0) nd = 1;
            it.n_dims = 3'($urandom_range(0, 19) == 0 ? $urandom_range(0, 7) : nd);
            for (int k = 0; k < 4; k++) begin
                dim = longint'($signed(slots[12'(it.handle + k)][31:0]));
                if (dim > 0 && $urandom_range(0, 9) != 0)
                    dim = $urandom_range(0, dim > 1000 ? 1000 : dim - 1);
                else
                    dim = $urandom_range(0, 1) ? dim : -1;
                case (k)
                    0: it.index_0 = 32'(dim);
                    1: it.index_1 = 32'(dim);
                    2: it.index_2 = 32'(dim);
                    default: it.index_3 = 32'(dim);
                endcase
            end
        end else if (pick < 92) begin
            it.op = OP_CLEAR;
            it.n_dims = 3'($urandom);
        end else begin
            // noise over the whole field ranges
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            it = in_item_t'(raw[$bits(in_item_t)-1:0]);
        end
        if (!touches_opened(it)) it.handle = '0;
        return it;
    endfunction

    // receiver: a stall pattern of its own, plus one long hold-off
    initial begin : receiver
        int unsigned cyc;
        cyc = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc >= 6000 && cyc < 6400) m_ready = 1'b0;
            else if (cyc % 2000 < 600) m_ready = 1'b1;
            else if (cyc % 2000 < 1200) m_ready = (cyc % 5) < 3;
            else m_ready = ($urandom_range(0, 3) != 0);
        end
    end

    // result check and watchdog
    always @(posedge aclk) begin : result_check
        int unsigned idle_cycles;
        out_item_t   exp_r;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("arena_array_store_tb: errors");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                n_errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_data.data !== exp_r.data) begin
                    $error("data: expected %h, got %h", exp_r.data, m_data.data);
                    n_errors++;
                end
                if (m_data.ok !== exp_r.ok) begin
                    $error("ok: expected %b, got %b", exp_r.ok, m_data.ok);
                    n_errors++;
                end
                if (m_data.handle_out !== exp_r.handle_out) begin
                    $error("handle_out: expected %h, got %h", exp_r.handle_out, m_data.handle_out);
                    n_errors++;
                end
            end
        end
    end

    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t r;
    } dir_row_t;

    initial begin : stimulus
        dir_row_t    rows [$];
        int unsigned burst;
        int          phase;
        int          ph_slots [5] = '{1023, 1, 24, 120, 1023};
        int          ph_limit [5] = '{4, 1, 2, 3, 4};

        for (int k = 0; k < MEM_WORDS; k++) slots[k] = '0;
        foreach (page_seen[k]) page_seen[k] = 1'b0;
        cur_pg = 0; nxt_slot = 1; room_left = 0; n_pages = 0;
        pg_slots_reg = 1023; pg_limit_reg = 4;

        // directed table: null handles, bad shapes, extremes, every operation
        rows.push_back('{mk(OP_READ, 0, 1, 0, 0, 0, 0, 0, 0), 1, res(ERR_NULL_INT, 0, 0)});
        rows.push_back('{mk(OP_READ, 1, 1, 0, 0, 0, 0, 0, 0), 1, res(ERR_NULL_DBL, 0, 0)});
        rows.push_back('{mk(OP_WRITE, 1, 1, 0, 0, 0, 0, 0, '1), 1, res(0, 0, 0)});
        rows.push_back('{mk(OP_CLEAR, 0, 1, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0)});
        rows.push_back('{mk(OP_ALLOC, 0, 0, 1, 1, 1, 1, 0, 0), 1, res(0, 0, 0)});
        rows.push_back('{mk(OP_ALLOC, 0, 5, 1, 1, 1, 1, 0, 0), 1, res(0, 0, 0)});
        rows.push_back('{mk(OP_ALLOC, 1, 1, 32'h8000_0000, 0, 0, 0, 0, 0), 1, res(0, 0, 0)});
        rows.push_back('{mk(OP_ALLOC, 0, 1, 0, 0, 0, 0, 0, 0), 1, res(0, 1, 1)});
        rows.push_back('{mk(OP_ALLOC, 1, 1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0), 1, res(0, 0, 0)});
        rows.push_back('{mk(OP_ALLOC, 1, 2, 2, 3, 0, 0, 0, 0), 1, res(0, 1, 3)});
        rows.push_back('{mk(OP_WRITE, 1, 2, 1, 2, 0, 0, 3, '1), 1, res(0, 1, 0)});
        rows.push_back('{mk(OP_READ, 1, 2, 1, 2, 0, 0, 3, 0), 1, res('1, 1, 0)});
        rows.push_back('{mk(OP_READ, 1, 2, 2, 0, 0, 0, 3, 0), 1, res(ERR_OOB_DBL, 0, 0)});
        rows.push_back('{mk(OP_READ, 1, 2, -1, 0, 0, 0, 3, 0), 1, res(ERR_OOB_DBL, 0, 0)});
        rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 0, 0, 3, 0), 1, res(ERR_OOB_INT, 0, 0)});
        rows.push_back('{mk(OP_ALLOC, 0, 4, 1, 2, 1, 3, 0, 0), 0, '0});
        rows.push_back('{mk(OP_WRITE, 0, 4, 0, 1, 0, 2, 11, 64'h1234_5678_FFFF_FFFF), 0, '0});
        rows.push_back('{mk(OP_READ, 0, 4, 0, 1, 0, 2, 11, 0), 0, '0});
        rows.push_back('{mk(OP_READ, 0, 4, 0, 1, 0, 1, 11, 0), 0, '0});
        rows.push_back('{mk(OP_WRITE, 0, 4, 0, 1, 0, 32'h7FFF_FFFF, 11, '1), 0, '0});
        rows.push_back('{mk(OP_ALLOC, 1, 1, 1000, -1, -1, -1, 0, 0), 0, '0});
        rows.push_back('{mk(OP_CLEAR, 1, 7, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0)});
        rows.push_back('{mk(OP_ALLOC, 0, 3, 2, 2, 2, 0, 0, 0), 0, '0});

        // reset
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[k]) send_item(rows[k].it, rows[k].typed, rows[k].r);

        // random part over several register settings
        for (phase = 0; phase < 5; phase++) begin
            write_config(ph_slots[phase], ph_limit[phase]);
            live_handles.delete();
            burst = 0;
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                if (burst == 0) begin
                    burst = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
                    if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 8));
                end
                burst--;
                send_item(random_item(), 1'b0, '0);
            end
        end
        sender_gap(1);

        // drain
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (n_errors == 0) $display("arena_array_store_tb: clean");
        else $display("arena_array_store_tb: errors");
        $finish;
    end

endmodule
